/* src/crc16fc_pkg.sv */
// Shared types, constants and the CRC byte update for the CRC-16 frame checker.
package crc16fc_pkg;

  // Reflected CRC-16 polynomial and register reset values
  localparam logic [15:0] CRC_POLY       = 16'h8408;
  localparam logic [7:0]  START_FIRST_RST  = 8'hA9;
  localparam logic [7:0]  START_SECOND_RST = 8'h53;
  localparam logic [15:0] CRC_INIT_RST   = 16'hFFFF;

  // Result width, and the master-side request width rounded up to whole bytes
  localparam int RES_W = 130;
  localparam int OUT_W = 136;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_START_FIRST  = 2'd0,
    REG_START_SECOND = 2'd1,
    REG_CRC_INIT     = 2'd2
  } cfg_reg_t;

  // Frame status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_WRONG_LEN = 2'd1,
    STAT_BAD_START = 2'd2,
    STAT_CRC_BAD   = 2'd3
  } frame_status_t;

  // Configuration register set
  typedef struct packed {
    logic [7:0]  start_first;
    logic [7:0]  start_second;
    logic [15:0] crc_init;
  } cfg_t;

  // One result; status sits in the lowest bits
  typedef struct packed {
    logic [31:0]   crc_bad_frames;
    logic [31:0]   bad_frames;
    logic [31:0]   good_frames;
    logic [15:0]   received_crc;
    logic [15:0]   computed_crc;
    frame_status_t frame_status;
  } res_t;

  // One byte step of the reflected CRC: crc = (crc >> 8) ^ T[(crc ^ b) & 0xFF]
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] t;
    t = {8'h00, crc[7:0] ^ b};
    for (int i = 0; i < 8; i++) begin
      t = t[0] ? ((t >> 1) ^ CRC_POLY) : (t >> 1);
    end
    return (crc >> 8) ^ t;
  endfunction

endpackage

/* src/crc16fc_core.sv */
// Input register, per-byte frame checking and frame counters.
module crc16fc_core #(
  parameter int FRAME_LEN = 21
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               end_of_frame,
  input  crc16fc_pkg::cfg_t  cfg,
  output logic               push,
  output crc16fc_pkg::res_t  res
);
  import crc16fc_pkg::*;

  localparam int IDX_W = $clog2(FRAME_LEN + 2);
  localparam logic [IDX_W-1:0] LEN_C  = IDX_W'(FRAME_LEN);
  localparam logic [IDX_W-1:0] BODY_C = IDX_W'(FRAME_LEN - 2);
  localparam logic [IDX_W-1:0] SAT_C  = IDX_W'(FRAME_LEN + 1);
  localparam logic [IDX_W-1:0] ONE_C  = IDX_W'(1);

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eof;

  // Frame state
  logic [IDX_W-1:0] byte_index;
  logic [15:0]      running_crc;
  logic             header_match;
  logic [15:0]      tail_bytes;
  logic [31:0]      good_count;
  logic [31:0]      bad_count;
  logic [31:0]      crc_bad_count;

  logic [IDX_W-1:0] byte_index_next;
  logic [15:0]      running_crc_next;
  logic             header_match_next;
  logic [15:0]      tail_bytes_next;
  logic [31:0]      good_count_next;
  logic [31:0]      bad_count_next;
  logic [31:0]      crc_bad_count_next;

  // Capture the accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
    if (accept) begin
      in_byte <= data_byte;
      in_eof  <= end_of_frame;
    end
  end

  // Update frame state with the held byte and build the frame verdict
  always_comb begin
    byte_index_next    = byte_index;
    running_crc_next   = running_crc;
    header_match_next  = header_match;
    tail_bytes_next    = tail_bytes;
    good_count_next    = good_count;
    bad_count_next     = bad_count;
    crc_bad_count_next = crc_bad_count;

    if (byte_index < LEN_C) begin
      if (byte_index == '0 && in_byte != cfg.start_first) begin
        header_match_next = 1'b0;
      end
      if (byte_index == ONE_C && in_byte != cfg.start_second) begin
        header_match_next = 1'b0;
      end
      if (byte_index < BODY_C) begin
        running_crc_next = crc_byte(running_crc, in_byte);
      end
      tail_bytes_next = {in_byte, tail_bytes[15:8]};
    end
    // Saturate one past the frame length
    if (byte_index < SAT_C) begin
      byte_index_next = byte_index + ONE_C;
    end

    res.computed_crc = running_crc_next;
    res.received_crc = tail_bytes_next;
    priority if (byte_index_next != LEN_C) begin
      res.frame_status = STAT_WRONG_LEN;
      res.computed_crc = '0;
      res.received_crc = '0;
      bad_count_next   = bad_count + 32'd1;
    end else if (!header_match_next) begin
      res.frame_status = STAT_BAD_START;
      bad_count_next   = bad_count + 32'd1;
    end else if (running_crc_next != tail_bytes_next) begin
      res.frame_status   = STAT_CRC_BAD;
      bad_count_next     = bad_count + 32'd1;
      crc_bad_count_next = crc_bad_count + 32'd1;
    end else begin
      res.frame_status = STAT_OK;
      good_count_next  = good_count + 32'd1;
    end
    res.good_frames    = good_count_next;
    res.bad_frames     = bad_count_next;
    res.crc_bad_frames = crc_bad_count_next;
  end

  assign push = in_valid && in_eof;

  // Advance state; restart the frame after its last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= '0;
      running_crc   <= CRC_INIT_RST;
      header_match  <= 1'b1;
      tail_bytes    <= '0;
      good_count    <= '0;
      bad_count     <= '0;
      crc_bad_count <= '0;
    end else if (in_valid) begin
      if (in_eof) begin
        byte_index    <= '0;
        running_crc   <= cfg.crc_init;
        header_match  <= 1'b1;
        tail_bytes    <= '0;
        good_count    <= good_count_next;
        bad_count     <= bad_count_next;
        crc_bad_count <= crc_bad_count_next;
      end else begin
        byte_index   <= byte_index_next;
        running_crc  <= running_crc_next;
        header_match <= header_match_next;
        tail_bytes   <= tail_bytes_next;
      end
    end
  end

endmodule

/* src/crc16fc_outq.sv */
// Two-entry result queue: output register plus skid entry.
module crc16fc_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  crc16fc_pkg::res_t push_data,
  input  logic              pop_ready,
  output logic              valid,
  output crc16fc_pkg::res_t head,
  output logic              room
);
  import crc16fc_pkg::*;

  logic [1:0] count;
  logic [1:0] count_next;
  res_t       entry1;
  logic       pop;

  assign valid = (count != 2'd0);
  assign pop   = valid && pop_ready;

  // Keep a slot free for the next request after this edge's push and pop
  always_comb begin
    unique case (count)
      2'd0:    room = 1'b1;
      2'd1:    room = !push || pop;
      2'd2:    room = pop && !push;
      default: room = 1'b0;
    endcase
  end

  always_comb begin
    count_next = count + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Shift the skid entry forward on pop, place the new result behind
  always_ff @(posedge clk) begin
    priority if (pop) begin
      if (count == 2'd2) begin
        head <= entry1;
        if (push) begin
          entry1 <= push_data;
        end
      end else if (push) begin
        head <= push_data;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        head <= push_data;
      end else begin
        entry1 <= push_data;
      end
    end else begin
      head <= head;
    end
  end

endmodule

/* src/crc16_frame_checker_top.sv */
// Top level of the CRC-16 frame checker.
//
// Usage:
//   Slave side carries received bytes: s_tdata[7:0] is the byte, s_tlast marks
//   the last byte before the line went idle. Each frame must be FRAME_LEN bytes,
//   start with the two programmed start bytes and end with a little-endian CRC-16
//   (reflected 0x8408) over the rest. On the byte with s_tlast the block emits
//   one result request on the master side with the frame status, the computed and
//   received CRC and the three wrapping frame counters.
//   Config port: cfg_index 0/1 set the start bytes, 2 sets the CRC start value
//   (used from the next frame start); other indexes are ignored. cfg_ready is
//   always high.
//   Throughput: one byte per cycle while s_tready is high. The byte passes an
//   input register, the CRC table update and frame checks, then enters a
//   two-entry result queue whose output register offers the result.
//   Reset clears counters and frame state, reloads register defaults and empties
//   the queue. A stalled master side holds its result; bytes keep flowing until
//   both queue entries are taken, then s_tready drops.
module crc16_frame_checker_top #(
  parameter int FRAME_LEN = 21
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // [7:0] data_byte
  input  logic                         s_tlast,   // end_of_frame
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [crc16fc_pkg::OUT_W-1:0] m_tdata,  // [1:0] frame_status,
                                                  // [17:2] computed_crc,
                                                  // [33:18] received_crc,
                                                  // [65:34] good_frames,
                                                  // [97:66] bad_frames,
                                                  // [129:98] crc_bad_frames, rest 0
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [15:0]                  cfg_data
);
  import crc16fc_pkg::*;

  cfg_t cfg;
  logic accept;
  logic push;
  res_t res;
  res_t head;
  logic room;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_first  <= START_FIRST_RST;
      cfg.start_second <= START_SECOND_RST;
      cfg.crc_init     <= CRC_INIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_FIRST:  cfg.start_first  <= cfg_data[7:0];
        REG_START_SECOND: cfg.start_second <= cfg_data[7:0];
        REG_CRC_INIT:     cfg.crc_init     <= cfg_data;
        default:          cfg <= cfg;
      endcase
    end
  end

  assign s_tready = room;
  assign accept   = s_tvalid && s_tready;

  crc16fc_core #(
    .FRAME_LEN(FRAME_LEN)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (s_tdata),
    .end_of_frame(s_tlast),
    .cfg         (cfg),
    .push        (push),
    .res         (res)
  );

  crc16fc_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(res),
    .pop_ready(m_tready),
    .valid    (m_tvalid),
    .head     (head),
    .room     (room)
  );

  assign m_tdata = {{(OUT_W - RES_W){1'b0}}, head};

endmodule

/* src/crc16fc_checker.sv */
// Port-level checks for the CRC-16 frame checker, bound to the top level.
module crc16fc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [crc16fc_pkg::OUT_W-1:0] m_tdata
);
  import crc16fc_pkg::*;

  // Queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered right after reset");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Wrong length reports zero CRC fields
  a_len_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == STAT_WRONG_LEN |-> m_tdata[33:2] == 32'd0)
    else $error("wrong-length result carries CRC values");

  // Good frame has matching CRCs
  a_ok_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == STAT_OK |-> m_tdata[17:2] == m_tdata[33:18])
    else $error("good frame with CRC mismatch");

  // CRC failure has differing CRCs
  a_crc_differ: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == STAT_CRC_BAD |-> m_tdata[17:2] != m_tdata[33:18])
    else $error("CRC failure with equal CRCs");

endmodule

bind crc16_frame_checker_top crc16fc_checker u_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
